// ===== design/hvd_pkg.sv =====
// Shared constants, types and elaboration-time tables for the haversine distance pipeline.
`timescale 1ns / 1ps

package hvd_pkg;

    localparam int CORDIC_STAGES = 32;
    localparam int SQRT_STEPS    = 32;
    localparam int SHIFT_W       = $clog2(CORDIC_STAGES);
    localparam int XY_W          = 36;
    localparam int LATENCY       = 2 * CORDIC_STAGES + SQRT_STEPS + 15;

    typedef logic        [SHIFT_W-1:0] t_shift;
    typedef logic signed [XY_W-1:0]    t_xy;
    typedef logic signed [63:0]        t_ang;
    typedef logic signed [36:0]        t_cc;

    localparam logic [63:0] ONE_Q60      = 64'h1000_0000_0000_0000;
    localparam logic [62:0] ONE_Q62      = 63'h4000_0000_0000_0000;
    localparam logic [63:0] HALF_TURN    = 64'd1800000000;
    localparam logic signed [32:0] TURN_UNITS = 33'sd3600000000;
    localparam logic signed [XY_W-1:0] GAIN_Q31 = 36'sd1304065748;
    localparam logic [22:0] RADIUS_RESET = 23'd6378137;
    localparam logic [63:0] ROUND_C38    = 64'h0000_0000_0020_0000;
    localparam logic [63:0] ROUND_Q8     = 64'h0000_0000_2000_0000;
    localparam logic [63:0] OUT_MAX      = 64'h0000_0001_FFFF_FFFF;

    // atan(1/5) in Q60 by its truncated series
    function automatic logic [63:0] f_atan_inv5();
        logic [63:0] t;
        logic [63:0] s;
        logic        done;
        t = ONE_Q60 / 64'd5;
        s = t;
        done = 1'b0;
        for (int k = 1; k < 64; k++) begin
            if (!done) begin
                t = t / 64'd25;
                if (t == 64'd0) begin
                    done = 1'b1;
                end else if (k % 2 == 1) begin
                    s = s - t / 64'(2 * k + 1);
                end else begin
                    s = s + t / 64'(2 * k + 1);
                end
            end
        end
        return s;
    endfunction

    // atan(1/239) in Q60 by its truncated series
    function automatic logic [63:0] f_atan_inv239();
        logic [63:0] t;
        logic [63:0] s;
        logic        done;
        t = ONE_Q60 / 64'd239;
        s = t;
        done = 1'b0;
        for (int k = 1; k < 64; k++) begin
            if (!done) begin
                t = t / 64'd57121;
                if (t == 64'd0) begin
                    done = 1'b1;
                end else if (k % 2 == 1) begin
                    s = s - t / 64'(2 * k + 1);
                end else begin
                    s = s + t / 64'(2 * k + 1);
                end
            end
        end
        return s;
    endfunction

    // atan(2^-i) in Q60, series with power-of-two steps
    function automatic logic [63:0] f_atan_pow2(input int i);
        logic [63:0] t;
        logic [63:0] s;
        logic        done;
        t = ONE_Q60 >> i;
        s = t;
        done = 1'b0;
        for (int k = 1; k < 64; k++) begin
            if (!done) begin
                t = t >> (2 * i);
                if (t == 64'd0) begin
                    done = 1'b1;
                end else if (k % 2 == 1) begin
                    s = s - t / 64'(2 * k + 1);
                end else begin
                    s = s + t / 64'(2 * k + 1);
                end
            end
        end
        return s;
    endfunction

    function automatic logic [63:0] f_atan(input int i);
        logic [63:0] v;
        if (i == 0) begin
            v = 64'd4 * f_atan_inv5() - f_atan_inv239();
        end else if (i < 61) begin
            v = f_atan_pow2(i);
        end else begin
            v = 64'd0;
        end
        return v;
    endfunction

    localparam logic [63:0] PI_Q60      = 64'd4 * f_atan(0);
    localparam logic [63:0] HALF_PI     = PI_Q60 >> 1;
    localparam logic [63:0] TWO_PI      = PI_Q60 << 1;
    localparam logic [63:0] PI_AND_HALF = PI_Q60 + HALF_PI;
    localparam logic [63:0] CONV_HI     = PI_Q60 / HALF_TURN;
    localparam logic [63:0] CONV_REM    = PI_Q60 % HALF_TURN;
    localparam logic [63:0] CONV_LO     = (CONV_REM << 32) / HALF_TURN;

endpackage

// ===== design/hvd_cordic_cell.sv =====
// One CORDIC micro-rotation cell, rotation or vectoring mode, registered outputs.
`timescale 1ns / 1ps

module hvd_cordic_cell (
    input  logic           i_clk,
    input  logic           i_adv,
    input  logic           i_vec_mode,
    input  hvd_pkg::t_shift i_shift,
    input  hvd_pkg::t_ang  i_atan,
    input  hvd_pkg::t_xy   i_x,
    input  hvd_pkg::t_xy   i_y,
    input  hvd_pkg::t_ang  i_z,
    output hvd_pkg::t_xy   o_x,
    output hvd_pkg::t_xy   o_y,
    output hvd_pkg::t_ang  o_z
);

    hvd_pkg::t_xy  w_xs;
    hvd_pkg::t_xy  w_ys;
    logic          w_pos;
    hvd_pkg::t_xy  n_x;
    hvd_pkg::t_xy  n_y;
    hvd_pkg::t_ang n_z;
    hvd_pkg::t_xy  r_x;
    hvd_pkg::t_xy  r_y;
    hvd_pkg::t_ang r_z;

    assign w_xs  = i_x >>> i_shift;
    assign w_ys  = i_y >>> i_shift;
    // rotation steers by the residual angle, vectoring by the sign of y
    assign w_pos = i_vec_mode ? (i_y <= 0) : (i_z >= 0);

    always_comb begin
        if (w_pos) begin
            n_x = i_x - w_ys;
            n_y = i_y + w_xs;
            n_z = i_z - i_atan;
        end else begin
            n_x = i_x + w_ys;
            n_y = i_y - w_xs;
            n_z = i_z + i_atan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;

endmodule

// ===== design/hvd_sqrt_cell.sv =====
// One step of the bit-by-bit integer square root, registered outputs.
`timescale 1ns / 1ps

module hvd_sqrt_cell (
    input  logic        i_clk,
    input  logic        i_adv,
    input  logic [63:0] i_bit,
    input  logic [63:0] i_v,
    input  logic [63:0] i_r,
    output logic [63:0] o_v,
    output logic [63:0] o_r
);

    logic [63:0] w_trial;
    logic [63:0] n_v;
    logic [63:0] n_r;
    logic [63:0] r_v;
    logic [63:0] r_r;

    assign w_trial = i_r + i_bit;

    always_comb begin
        if (i_v >= w_trial) begin
            n_v = i_v - w_trial;
            n_r = (i_r >> 1) + i_bit;
        end else begin
            n_v = i_v;
            n_r = i_r >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_v <= n_v;
            r_r <= n_r;
        end
    end

    assign o_v = r_v;
    assign o_r = r_r;

endmodule

// ===== design/haversine_distance.sv =====
// Haversine great-circle distance pipeline: top level.
// Depth: 2*CORDIC_STAGES + SQRT_STEPS + 15 = 111 register stages; the valid bits shift
//   alongside the payload, so o_valid rises together with its result on o_distance_q8.
// Throughput: one transaction per cycle while o_stall is low; the whole pipeline advances as one unit,
//   so a held output freezes every stage and raises o_stall.
// Reset (synchronous, active low): clears every stage valid bit and loads the
//   radius register with 6378137 m; payload registers keep their contents.
`timescale 1ns / 1ps

module haversine_distance (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [30:0] i_lat_a,
    input  logic signed [31:0] i_lon_a,
    input  logic signed [30:0] i_lat_b,
    input  logic signed [31:0] i_lon_b,
    output logic               o_valid,
    input  logic               i_stall,
    output logic        [32:0] o_distance_q8,
    input  logic               i_cfg_wr_en,
    input  logic        [22:0] i_cfg_wr_data
);

    localparam int S = hvd_pkg::CORDIC_STAGES;
    localparam int Q = hvd_pkg::SQRT_STEPS;
    localparam int L = hvd_pkg::LATENCY;

    // ---------------------------------------------------------------
    // Flow control: one advance enable for every stage. Stages move
    // whenever the output register is empty or being taken.
    // ---------------------------------------------------------------
    logic         w_adv;
    logic [L-1:0] r_vld;
    logic [22:0]  r_radius;

    assign w_adv   = !r_vld[L-1] || !i_stall;
    assign o_stall = !w_adv;
    assign o_valid = r_vld[L-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[L-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= hvd_pkg::RADIUS_RESET;
        end else if (i_cfg_wr_en) begin
            r_radius <= i_cfg_wr_data;
        end
    end

    // ---------------------------------------------------------------
    // Input capture
    // ---------------------------------------------------------------
    logic signed [30:0] r_lat_a;
    logic signed [31:0] r_lon_a;
    logic signed [30:0] r_lat_b;
    logic signed [31:0] r_lon_b;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_lat_a <= i_lat_a;
            r_lon_a <= i_lon_a;
            r_lat_b <= i_lat_b;
            r_lon_b <= i_lon_b;
        end
    end

    // ---------------------------------------------------------------
    // Fold every coordinate into one turn [0, 3.6e9), then form the
    // wrapped differences. Inputs never reach a full turn in magnitude,
    // so one conditional add does the reduction.
    // ---------------------------------------------------------------
    logic signed [32:0] w_e [4];
    logic        [31:0] w_red [4];
    logic        [31:0] r_red [4];

    assign w_e[0] = 33'(r_lat_a);
    assign w_e[1] = 33'(r_lat_b);
    assign w_e[2] = 33'(r_lon_a);
    assign w_e[3] = 33'(r_lon_b);

    always_comb begin
        for (int j = 0; j < 4; j++) begin
            w_red[j] = (w_e[j] < 0) ? 32'(w_e[j] + hvd_pkg::TURN_UNITS) : w_e[j][31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_red <= w_red;
        end
    end

    logic signed [32:0] w_dlat;
    logic signed [32:0] w_dlon;
    logic        [31:0] r_units [4];

    assign w_dlat = $signed({1'b0, r_red[1]}) - $signed({1'b0, r_red[0]});
    assign w_dlon = $signed({1'b0, r_red[3]}) - $signed({1'b0, r_red[2]});

    // angle order through the trig section: half dlat, half dlon, lat a, lat b
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_units[0] <= (w_dlat < 0) ? 32'(w_dlat + hvd_pkg::TURN_UNITS) : w_dlat[31:0];
            r_units[1] <= (w_dlon < 0) ? 32'(w_dlon + hvd_pkg::TURN_UNITS) : w_dlon[31:0];
            r_units[2] <= r_red[0];
            r_units[3] <= r_red[1];
        end
    end

    // ---------------------------------------------------------------
    // Units to Q60 radians: split the conversion factor into a high and
    // a low 32-bit word, two 32x32 products per angle.
    // ---------------------------------------------------------------
    logic [63:0] r_phi [4];
    logic [63:0] r_plo [4];
    logic [63:0] r_ang [4];
    logic [63:0] w_sum [4];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int j = 0; j < 4; j++) begin
                r_phi[j] <= {32'b0, r_units[j]} * hvd_pkg::CONV_HI;
                r_plo[j] <= {32'b0, r_units[j]} * hvd_pkg::CONV_LO;
            end
        end
    end

    always_comb begin
        for (int j = 0; j < 4; j++) begin
            w_sum[j] = r_phi[j] + (r_plo[j] >> 32);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_ang[0] <= w_sum[0] >> 1;
            r_ang[1] <= w_sum[1] >> 1;
            r_ang[2] <= w_sum[2];
            r_ang[3] <= w_sum[3];
        end
    end

    // ---------------------------------------------------------------
    // Quadrant fold into [-pi/2, pi/2]; the flag negates sin and cos at
    // the far end of the rotation chain.
    // ---------------------------------------------------------------
    hvd_pkg::t_ang n_th  [4];
    logic    [3:0] n_neg;
    hvd_pkg::t_ang r_th  [4];
    logic    [3:0] r_neg;

    always_comb begin
        for (int j = 0; j < 4; j++) begin
            if (r_ang[j] > hvd_pkg::PI_AND_HALF) begin
                n_th[j]  = $signed(r_ang[j] - hvd_pkg::TWO_PI);
                n_neg[j] = 1'b0;
            end else if (r_ang[j] > hvd_pkg::HALF_PI) begin
                n_th[j]  = $signed(r_ang[j] - hvd_pkg::PI_Q60);
                n_neg[j] = 1'b1;
            end else begin
                n_th[j]  = $signed(r_ang[j]);
                n_neg[j] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_th  <= n_th;
            r_neg <= n_neg;
        end
    end

    // ---------------------------------------------------------------
    // Four rotation chains of S cells each, running side by side.
    // ---------------------------------------------------------------
    hvd_pkg::t_xy  w_rx [4][S+1];
    hvd_pkg::t_xy  w_ry [4][S+1];
    hvd_pkg::t_ang w_rz [4][S+1];
    logic [3:0]    r_negp [S];

    for (genvar c = 0; c < 4; c++) begin : g_rot
        assign w_rx[c][0] = hvd_pkg::GAIN_Q31;
        assign w_ry[c][0] = '0;
        assign w_rz[c][0] = r_th[c];
        for (genvar k = 0; k < S; k++) begin : g_cell
            hvd_cordic_cell u_cell (
                .i_clk      (i_clk),
                .i_adv      (w_adv),
                .i_vec_mode (1'b0),
                .i_shift    (hvd_pkg::t_shift'(k)),
                .i_atan     ($signed(hvd_pkg::f_atan(k))),
                .i_x        (w_rx[c][k]),
                .i_y        (w_ry[c][k]),
                .i_z        (w_rz[c][k]),
                .o_x        (w_rx[c][k+1]),
                .o_y        (w_ry[c][k+1]),
                .o_z        (w_rz[c][k+1])
            );
        end
    end

    // carry the fold flags alongside the chain
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_negp[0] <= r_neg;
            for (int k = 1; k < S; k++) begin
                r_negp[k] <= r_negp[k-1];
            end
        end
    end

    // ---------------------------------------------------------------
    // Pick sin of the half differences and cos of both latitudes.
    // ---------------------------------------------------------------
    hvd_pkg::t_xy r_s1;
    hvd_pkg::t_xy r_s2;
    hvd_pkg::t_xy r_c1;
    hvd_pkg::t_xy r_c2;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1 <= r_negp[S-1][0] ? -w_ry[0][S] : w_ry[0][S];
            r_s2 <= r_negp[S-1][1] ? -w_ry[1][S] : w_ry[1][S];
            r_c1 <= r_negp[S-1][2] ? -w_rx[2][S] : w_rx[2][S];
            r_c2 <= r_negp[S-1][3] ? -w_rx[3][S] : w_rx[3][S];
        end
    end

    // ---------------------------------------------------------------
    // a = s1^2 + cc * s2^2, the last product split at bit 31 so that
    // no multiplier grows past the native width.
    // ---------------------------------------------------------------
    logic signed [71:0] r_pcc;
    logic signed [71:0] r_s1sq;
    logic signed [71:0] r_s2sq;
    logic signed [71:0] r_s1sq_d2;
    logic signed [71:0] r_s1sq_d3;
    logic signed [71:0] r_mhi;
    logic signed [71:0] r_mlo;
    logic signed [71:0] r_t2;
    hvd_pkg::t_cc       w_cc;
    logic        [32:0] w_hi;
    logic        [30:0] w_lo;
    logic signed [71:0] w_asum;
    logic        [62:0] r_a;
    logic        [63:0] r_va;
    logic        [63:0] r_vb;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_pcc  <= r_c1 * r_c2;
            r_s1sq <= r_s1 * r_s1;
            r_s2sq <= r_s2 * r_s2;
        end
    end

    assign w_cc = hvd_pkg::t_cc'(r_pcc >>> 31);
    assign w_hi = r_s2sq[63:31];
    assign w_lo = r_s2sq[30:0];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_mhi     <= w_cc * $signed({1'b0, w_hi});
            r_mlo     <= w_cc * $signed({1'b0, w_lo});
            r_s1sq_d2 <= r_s1sq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_t2      <= r_mhi + (r_mlo >>> 31);
            r_s1sq_d3 <= r_s1sq_d2;
        end
    end

    assign w_asum = r_s1sq_d3 + r_t2;

    // clamp a into [0, 1]
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            if (w_asum < 0) begin
                r_a <= '0;
            end else if (w_asum > $signed({9'b0, hvd_pkg::ONE_Q62})) begin
                r_a <= hvd_pkg::ONE_Q62;
            end else begin
                r_a <= w_asum[62:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_va <= {1'b0, r_a};
            r_vb <= {1'b0, hvd_pkg::ONE_Q62 - r_a};
        end
    end

    // ---------------------------------------------------------------
    // Two square-root chains: index 0 takes a, index 1 takes 1 - a.
    // ---------------------------------------------------------------
    logic [63:0] w_qv [2][Q+1];
    logic [63:0] w_qr [2][Q+1];

    assign w_qv[0][0] = r_va;
    assign w_qv[1][0] = r_vb;

    for (genvar j = 0; j < 2; j++) begin : g_sqrt
        assign w_qr[j][0] = '0;
        for (genvar k = 0; k < Q; k++) begin : g_step
            hvd_sqrt_cell u_step (
                .i_clk (i_clk),
                .i_adv (w_adv),
                .i_bit (64'd1 << (2 * (Q - 1 - k))),
                .i_v   (w_qv[j][k]),
                .i_r   (w_qr[j][k]),
                .o_v   (w_qv[j][k+1]),
                .o_r   (w_qr[j][k+1])
            );
        end
    end

    // ---------------------------------------------------------------
    // Vectoring chain: angle of (sqrt(1-a), sqrt(a)).
    // ---------------------------------------------------------------
    hvd_pkg::t_xy  w_vx [S+1];
    hvd_pkg::t_xy  w_vy [S+1];
    hvd_pkg::t_ang w_vz [S+1];

    assign w_vx[0] = hvd_pkg::t_xy'(w_qr[1][Q]);
    assign w_vy[0] = hvd_pkg::t_xy'(w_qr[0][Q]);
    assign w_vz[0] = '0;

    for (genvar k = 0; k < S; k++) begin : g_vec
        hvd_cordic_cell u_cell (
            .i_clk      (i_clk),
            .i_adv      (w_adv),
            .i_vec_mode (1'b1),
            .i_shift    (hvd_pkg::t_shift'(k)),
            .i_atan     ($signed(hvd_pkg::f_atan(k))),
            .i_x        (w_vx[k]),
            .i_y        (w_vy[k]),
            .i_z        (w_vz[k]),
            .o_x        (w_vx[k+1]),
            .o_y        (w_vy[k+1]),
            .o_z        (w_vz[k+1])
        );
    end

    // ---------------------------------------------------------------
    // Central angle c = 2z rounded to Q38, times radius, rounded to Q8
    // and saturated at 33 bits.
    // ---------------------------------------------------------------
    logic [63:0] w_zc;
    logic [63:0] w_c38;
    logic [41:0] r_c38;
    logic [63:0] r_prod;
    logic [63:0] w_q8;
    logic [32:0] r_out;

    assign w_zc  = (w_vz[S] < 0) ? 64'd0 : w_vz[S];
    assign w_c38 = ({w_zc[62:0], 1'b0} + hvd_pkg::ROUND_C38) >> 22;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_c38 <= w_c38[41:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_prod <= {22'b0, r_c38} * {41'b0, r_radius};
        end
    end

    assign w_q8 = (r_prod + hvd_pkg::ROUND_Q8) >> 30;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= (w_q8 > hvd_pkg::OUT_MAX) ? hvd_pkg::OUT_MAX[32:0] : w_q8[32:0];
        end
    end

    assign o_distance_q8 = r_out;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> $stable(r_vld))
        else $error("pipeline moved while output held");

    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_vld[0])
        else $error("accepted transaction missing from first stage");

    a_a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[S+10] |-> (r_a <= hvd_pkg::ONE_Q62))
        else $error("haversine term left [0, 1]");

    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> (r_vld[L-2] || $past(r_vld[L-2])))
        else $error("output valid without a transaction behind it");

endmodule

// ===== tb/haversine_distance_tb.sv =====
// Self-checking testbench for the haversine great-circle distance pipeline.
`timescale 1ns / 1ps

module haversine_distance_tb;

    localparam int  STAGES      = hvd_pkg::CORDIC_STAGES;
    localparam int  IDLE_LIMIT  = 5000;
    localparam int  HOLD_CYCLES = 400;
    localparam longint TURN     = 64'sd3600000000;

    typedef struct {
        logic signed [30:0] lat_a;
        logic signed [31:0] lon_a;
        logic signed [30:0] lat_b;
        logic signed [31:0] lon_b;
    } t_point_pair;

    logic               i_clk;
    logic               i_rst_n       = 1'b0;
    logic               i_valid       = 1'b0;
    logic               o_stall;
    logic signed [30:0] i_lat_a       = '0;
    logic signed [31:0] i_lon_a       = '0;
    logic signed [30:0] i_lat_b       = '0;
    logic signed [31:0] i_lon_b       = '0;
    logic               o_valid;
    logic               i_stall       = 1'b0;
    logic        [32:0] o_distance_q8;
    logic               i_cfg_wr_en   = 1'b0;
    logic        [22:0] i_cfg_wr_data = '0;

    haversine_distance dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_lat_a       (i_lat_a),
        .i_lon_a       (i_lon_a),
        .i_lat_b       (i_lat_b),
        .i_lon_b       (i_lon_b),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_distance_q8 (o_distance_q8),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    // Predictor state: radius copy and the constant tables.
    longint unsigned radius_m = 64'd6378137;
    longint          arctan_q60 [STAGES];
    longint          pi_rad_q60;
    longint unsigned deg_to_rad_hi;
    longint unsigned deg_to_rad_lo;

    t_point_pair      pending_pairs [$];
    logic      [32:0] dist_expected [$];
    int               mismatches  = 0;
    int               unexpected  = 0;
    int               outputs_seen = 0;
    bit               no_idle     = 1'b0;
    int               idle_cycles = 0;

    // Truncated arctan series of 1/n in Q60.
    function automatic longint unsigned arctan_recip(longint unsigned n);
        longint unsigned t, sum, k;
        t = (64'd1 << 60) / n;
        sum = t;
        k = 1;
        forever begin
            t = t / n / n;
            if (t == 0) break;
            if (k[0]) sum -= t / (2 * k + 1);
            else      sum += t / (2 * k + 1);
            k++;
        end
        return sum;
    endfunction

    function automatic void init_tables();
        longint unsigned q, rem;
        arctan_q60[0] = 4 * arctan_recip(5) - arctan_recip(239);
        for (int i = 1; i < STAGES; i++) arctan_q60[i] = arctan_recip(64'd1 << i);
        pi_rad_q60 = 4 * arctan_q60[0];
        q   = pi_rad_q60 / 64'd1800000000;
        rem = pi_rad_q60 % 64'd1800000000;
        deg_to_rad_hi = q;
        deg_to_rad_lo = (rem << 32) / 64'd1800000000;
    endfunction

    function automatic longint wrap_turn(longint v);
        longint r;
        r = v % TURN;
        if (r < 0) r += TURN;
        return r;
    endfunction

    function automatic longint units_to_rad(longint r);
        longint unsigned u;
        u = r;
        return u * deg_to_rad_hi + ((u * deg_to_rad_lo) >> 32);
    endfunction

    // Rotation CORDIC with quadrant fold; returns cosine and sine in Q31.
    function automatic void rotate(longint th, output longint co, output longint si);
        longint x, y, nx, half;
        bit     flip;
        half = pi_rad_q60 >>> 1;
        x = 1304065748;
        y = 0;
        flip = 1'b0;
        if (th > pi_rad_q60 + half) begin
            th -= 2 * pi_rad_q60;
        end else if (th > half) begin
            th -= pi_rad_q60;
            flip = 1'b1;
        end
        for (int i = 0; i < STAGES; i++) begin
            if (th >= 0) begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                th -= arctan_q60[i];
            end else begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                th += arctan_q60[i];
            end
            x = nx;
        end
        co = flip ? -x : x;
        si = flip ? -y : y;
    endfunction

    function automatic longint vector_atan(longint x, longint y);
        longint z, nx;
        z = 0;
        for (int i = 0; i < STAGES; i++) begin
            if (y > 0) begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z += arctan_q60[i];
            end else begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z -= arctan_q60[i];
            end
            x = nx;
        end
        return z;
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic [32:0] great_circle_q8(t_point_pair p);
        longint ra, rb, dlat, dlon, s1, s2, c1, c2, dummy, cc, t2, a, z;
        longint unsigned s2sq, c38, q8;
        ra = wrap_turn(longint'(p.lat_a));
        rb = wrap_turn(longint'(p.lat_b));
        dlat = rb - ra;
        if (dlat < 0) dlat += TURN;
        dlon = wrap_turn(longint'(p.lon_b)) - wrap_turn(longint'(p.lon_a));
        if (dlon < 0) dlon += TURN;
        rotate(units_to_rad(dlat) >>> 1, dummy, s1);
        rotate(units_to_rad(dlon) >>> 1, dummy, s2);
        rotate(units_to_rad(ra), c1, dummy);
        rotate(units_to_rad(rb), c2, dummy);
        cc   = (c1 * c2) >>> 31;
        s2sq = s2 * s2;
        t2   = cc * longint'(s2sq >> 31) + ((cc * longint'(s2sq & 64'h7FFF_FFFF)) >>> 31);
        a    = s1 * s1 + t2;
        // clamp a into [0, 1]
        if (a < 0) a = 0;
        if (a > (64'sd1 <<< 62)) a = 64'sd1 <<< 62;
        z = vector_atan(floor_sqrt((64'd1 << 62) - a), floor_sqrt(a));
        if (z < 0) z = 0;
        c38 = ((2 * z) + (64'd1 << 21)) >> 22;
        q8  = (c38 * radius_m + (64'd1 << 29)) >> 30;
        if (q8 > 64'h1_FFFF_FFFF) q8 = 64'h1_FFFF_FFFF;
        return q8[32:0];
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Driver: present queued pairs, push the expected distance on each transaction.
    int gap_left = 0;
    always @(posedge i_clk) begin
        t_point_pair nxt;
        int g;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                dist_expected.push_back(great_circle_q8('{i_lat_a, i_lon_a, i_lat_b, i_lon_b}));
                g = pick_gap();
                if (g == 0 && pending_pairs.size() > 0) begin
                    nxt = pending_pairs.pop_front();
                    i_lat_a <= nxt.lat_a;
                    i_lon_a <= nxt.lon_a;
                    i_lat_b <= nxt.lat_b;
                    i_lon_b <= nxt.lon_b;
                end else begin
                    i_valid  <= 1'b0;
                    gap_left <= g;
                end
            end else if (!i_valid) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                end else if (pending_pairs.size() > 0) begin
                    nxt = pending_pairs.pop_front();
                    i_valid <= 1'b1;
                    i_lat_a <= nxt.lat_a;
                    i_lon_a <= nxt.lon_a;
                    i_lat_b <= nxt.lat_b;
                    i_lon_b <= nxt.lon_b;
                end
            end
        end
    end

    // Receiver stall: random gaps plus one long hold-off, started while plenty of
    // pairs are still queued so the sender keeps offering and the pipeline backs up.
    int  stall_left = 0;
    int  hold_left  = 0;
    bit  hold_done  = 1'b0;
    always @(posedge i_clk) begin
        int r;
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else if (!hold_done && o_valid && pending_pairs.size() >= 20) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            i_stall   <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_stall    <= 1'b1;
        end else if (no_idle) begin
            i_stall <= 1'b0;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 72) begin
                i_stall <= 1'b0;
            end else if (r < 95) begin
                i_stall    <= 1'b1;
                stall_left <= $urandom_range(0, 2);
            end else begin
                i_stall    <= 1'b1;
                stall_left <= $urandom_range(10, 40);
            end
        end
    end

    // Monitor: compare each output transaction with the oldest expectation.
    always @(posedge i_clk) begin
        logic [32:0] want;
        if (i_rst_n && o_valid && !i_stall) begin
            outputs_seen <= outputs_seen + 1;
            if (dist_expected.size() == 0) begin
                unexpected <= unexpected + 1;
                if (mismatches + unexpected < 10)
                    $display("unexpected output: distance_q8=%0d", o_distance_q8);
            end else begin
                want = dist_expected.pop_front();
                if (o_distance_q8 !== want) begin
                    mismatches <= mismatches + 1;
                    if (mismatches + unexpected < 10)
                        $display("distance_q8 mismatch: expected %0d, got %0d",
                                 want, o_distance_q8);
                end
            end
        end
    end

    // Watchdog: stop when nothing moves on either side for too long.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("haversine_distance test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic int rand_lat();
        return int'($urandom_range(0, 1800000000)) - 900000000;
    endfunction

    function automatic int rand_lon();
        return int'($urandom_range(0, 2000000000)) + int'($urandom_range(0, 1600000000))
               - 1800000000;
    endfunction

    task automatic add_pair(int la, int loa, int lb, int lob);
        pending_pairs.push_back('{la[30:0], loa, lb[30:0], lob});
    endtask

    // Wait for the pipeline to drain, then let it settle before touching the radius.
    task automatic drain();
        wait (pending_pairs.size() == 0 && !i_valid && dist_expected.size() == 0);
        repeat (hvd_pkg::LATENCY + 10) @(posedge i_clk);
    endtask

    task automatic write_radius(logic [22:0] r);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= r;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        radius_m = r;
    endtask

    // Mostly realistic coordinates, some nearby pairs, some raw full-width words.
    task automatic random_batch(int n);
        int la, loa, r;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                add_pair(rand_lat(), rand_lon(), rand_lat(), rand_lon());
            end else if (r < 80) begin
                la  = rand_lat();
                loa = rand_lon();
                add_pair(la, loa, la + int'($urandom_range(0, 20000)) - 10000,
                         loa + int'($urandom_range(0, 20000)) - 10000);
            end else begin
                add_pair($urandom, $urandom, $urandom, $urandom);
            end
        end
    endtask

    initial begin
        logic [22:0] radii [6] = '{23'd6300000, 23'd6400000, 23'd0, 23'h7FFFFF, 23'd1,
                                   23'd6371000};
        init_tables();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: identical points, poles, date line, antipodes, field extremes.
        add_pair(0, 0, 0, 0);
        add_pair(900000000, 0, -900000000, 0);
        add_pair(0, 0, 0, 1800000000);
        add_pair(0, -1800000000, 0, 1800000000);
        add_pair(0, 1799999999, 0, -1799999999);
        add_pair(-900000000, -1800000000, 900000000, 1800000000);
        add_pair(450000000, 0, -450000000, 1800000000);
        add_pair(0, 0, 1, 0);
        add_pair(0, 0, 0, 1);
        add_pair(900000000, 123456789, 900000000, -987654321);
        add_pair(-(1 << 30), 0, (1 << 30) - 1, 0);
        add_pair((1 << 30) - 1, 32'sh7FFFFFFF, -(1 << 30), 32'sh80000000);
        add_pair(32'sh7FFFFFFF, 32'sh80000000, 0, 0);
        add_pair(-1, -1, -1, -1);
        add_pair(0, 900000000, 0, -900000000);
        add_pair(514000000, -1000000, 407000000, -740000000);
        add_pair(-337000000, 1512000000, 515000000, -1000000);
        add_pair(899999999, 0, -899999999, 1800000000);
        drain();

        no_idle = 1'b1;
        random_batch(150);
        drain();
        no_idle = 1'b0;

        foreach (radii[i]) begin
            write_radius(radii[i]);
            random_batch(150);
            drain();
        end

        write_radius(23'(6300000 + $urandom_range(0, 100000)));
        random_batch(30);
        drain();

        if (mismatches == 0 && unexpected == 0 && dist_expected.size() == 0) begin
            $display("haversine_distance test passed");
        end else begin
            $display("haversine_distance test failed");
        end
        $finish;
    end

endmodule
